/* sv/threshold_region_counter_defines.svh */
// Assertion macros for the threshold region counter.
`ifndef THRESHOLD_REGION_COUNTER_DEFINES_SVH
`define THRESHOLD_REGION_COUNTER_DEFINES_SVH

`ifndef SYNTH

// Condition must never hold outside reset.
`define TCR_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tcr: forbidden condition seen");

// Same-cycle implication.
`define TCR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcr: implication failed");

// Next-cycle implication.
`define TCR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcr: next-cycle implication failed");

`else

`define TCR_ASSERT_NEVER(lbl, clk, rst, cond)
`define TCR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TCR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/tcr_pkg.sv */
// Shared constants, direction codes and controller/datapath interface types.
`default_nettype none

package tcr_pkg;

  localparam int GRID_MAX    = 64;
  localparam int HEIGHT_MAX  = 255;
  localparam int CELL_COUNT  = GRID_MAX * GRID_MAX;
  localparam int ADDR_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int IDX_W       = $clog2(CELL_COUNT + 1);
  localparam int COORD_W     = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int RC_W        = 2 * COORD_W;
  localparam int VIS_DEPTH   = 1 << RC_W;
  localparam int SIDE_W      = 7;
  localparam int HEIGHT_W    = 8;
  localparam int COUNT_W     = 12;
  localparam int LEVEL_W     = 8;
  localparam int LEVEL_TOP   = (HEIGHT_MAX < 255) ? HEIGHT_MAX : 255;
  localparam int COUNT_LIMIT = 4095;
  localparam int EXT_W       = ((SIDE_W > COORD_W) ? SIDE_W : COORD_W) + 1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  // Neighbor directions walked from a popped cell
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_wr;
    logic start;
    logic init_rd;
    logic scan_rd;
    logic scan_hit;
    logic scan_next;
    logic pop_rd;
    logic pop_take;
    logic nb_rd;
    logic nb_push;
    logic nb_next;
    logic level_end;
    logic emit;
  } tcr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic init_last;
    logic scan_last;
    logic vis_free;
    logic sp_zero;
    logic nb_ok;
    logic nb_last;
    logic level_last;
  } tcr_sts_t;

endpackage

`default_nettype wire

/* sv/tcr_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module tcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/tcr_ctrl.sv */
// Sequencer: load phase, per-level flood/scan/walk, and result hand-off.
`default_nettype none

module tcr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              last_cell,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tcr_pkg::tcr_cmd_t      cmd,
  input  wire tcr_pkg::tcr_sts_t sts
);

  import tcr_pkg::*;

  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_INIT      = 4'd1;
  localparam logic [3:0] S_INIT_TAIL = 4'd2;
  localparam logic [3:0] S_SCAN_RD   = 4'd3;
  localparam logic [3:0] S_SCAN_CHK  = 4'd4;
  localparam logic [3:0] S_POP       = 4'd5;
  localparam logic [3:0] S_POP_WAIT  = 4'd6;
  localparam logic [3:0] S_NB_RD     = 4'd7;
  localparam logic [3:0] S_NB_CHK    = 4'd8;
  localparam logic [3:0] S_LEVEL_END = 4'd9;
  localparam logic [3:0] S_EMIT      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_LOAD);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (last_cell) begin
            cmd.start  = 1'b1;
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init_rd = 1'b1;
        if (sts.init_last) begin
          state_next = S_INIT_TAIL;
        end
      end
      S_INIT_TAIL: begin
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.vis_free) begin
          cmd.scan_hit = 1'b1;
          state_next   = S_POP;
        end else if (sts.scan_last) begin
          state_next = S_LEVEL_END;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_POP: begin
        if (sts.sp_zero) begin
          if (sts.scan_last) begin
            state_next = S_LEVEL_END;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_SCAN_RD;
          end
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.pop_take = 1'b1;
        state_next   = S_NB_RD;
      end
      S_NB_RD: begin
        if (sts.nb_ok) begin
          cmd.nb_rd  = 1'b1;
          state_next = S_NB_CHK;
        end else if (sts.nb_last) begin
          state_next = S_POP;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_NB_CHK: begin
        cmd.nb_push = sts.vis_free;
        if (sts.nb_last) begin
          state_next = S_POP;
        end else begin
          cmd.nb_next = 1'b1;
          state_next  = S_NB_RD;
        end
      end
      S_LEVEL_END: begin
        cmd.level_end = 1'b1;
        state_next    = sts.level_last ? S_EMIT : S_INIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Output register valid: set on emit, cleared when the request is taken
  assign out_valid_next = cmd.emit | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tcr_datapath.sv */
// Datapath: side register, height/visited/stack memories, counters and result.
`default_nettype none

module tcr_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [tcr_pkg::SIDE_W-1:0]     cfg_wr_data,
  input  wire logic [tcr_pkg::HEIGHT_W-1:0]   height,
  output logic      [tcr_pkg::COUNT_W-1:0]    max_regions,
  input  wire tcr_pkg::tcr_cmd_t              cmd,
  output tcr_pkg::tcr_sts_t                   sts
);

  import tcr_pkg::*;

  // True when coordinate v is the last one of a side s
  function automatic logic at_edge(input logic [COORD_W-1:0] v,
                                   input logic [EXT_W-1:0]   s);
    return (EXT_W'(v) + EXT_W'(1)) == s;
  endfunction

  logic [SIDE_W-1:0]   grid_side;
  logic [SIDE_W-1:0]   side_live;
  logic [2*SIDE_W-1:0] cells_live;
  logic                load_ok;
  logic [IDX_W-1:0]    load_index;

  logic [SIDE_W-1:0]   side;
  logic [EXT_W-1:0]    side_x;
  logic [LEVEL_W-1:0]  level;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  best;

  logic [ADDR_W-1:0]   init_idx;
  logic [COORD_W-1:0]  ir;
  logic [COORD_W-1:0]  ic;
  logic                pend_valid;
  logic [RC_W-1:0]     pend_rc;

  logic [COORD_W-1:0]  sr;
  logic [COORD_W-1:0]  sc;
  logic [IDX_W-1:0]    sp;
  logic [IDX_W-1:0]    sp_m1;
  logic [COORD_W-1:0]  cur_r;
  logic [COORD_W-1:0]  cur_c;
  logic [1:0]          nb;
  logic [COORD_W-1:0]  nb_r;
  logic [COORD_W-1:0]  nb_c;
  logic                nb_ok;

  logic [HEIGHT_W-1:0] h_rdata;
  logic                vis_we;
  logic [RC_W-1:0]     vis_waddr;
  logic                vis_wdata;
  logic                vis_re;
  logic [RC_W-1:0]     vis_raddr;
  logic                vis_rdata;
  logic                stk_we;
  logic [ADDR_W-1:0]   stk_waddr;
  logic [RC_W-1:0]     stk_wdata;
  logic [RC_W-1:0]     stk_rdata;

  // Side in force: zero acts as one, large values saturate
  always_comb begin
    if (grid_side == '0) begin
      side_live = SIDE_W'(1);
    end else if (int'(grid_side) > GRID_MAX) begin
      side_live = SIDE_W'(GRID_MAX);
    end else begin
      side_live = grid_side;
    end
  end

  assign cells_live = (2*SIDE_W)'(side_live) * (2*SIDE_W)'(side_live);
  assign load_ok    = int'(load_index) < int'(cells_live);
  assign side_x     = EXT_W'(side);
  assign sp_m1      = sp - IDX_W'(1);

  // Neighbor of the popped cell in the current direction
  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    unique case (nb)
      DIR_RIGHT: begin
        nb_ok = !at_edge(cur_c, side_x);
        nb_c  = cur_c + COORD_W'(1);
      end
      DIR_LEFT: begin
        nb_ok = (cur_c != '0);
        nb_c  = cur_c - COORD_W'(1);
      end
      DIR_DOWN: begin
        nb_ok = !at_edge(cur_r, side_x);
        nb_r  = cur_r + COORD_W'(1);
      end
      DIR_UP: begin
        nb_ok = (cur_r != '0);
        nb_r  = cur_r - COORD_W'(1);
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side  <= SIDE_RESET;
      load_index <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grid_side <= cfg_wr_data;
      end
      if (cmd.start) begin
        load_index <= '0;
      end else if (cmd.load_wr && load_ok) begin
        load_index <= load_index + IDX_W'(1);
      end
      pend_valid <= cmd.init_rd;
    end
  end

  // Walk state, counters and result
  always_ff @(posedge clk) begin
    pend_rc <= {ir, ic};
    if (cmd.start) begin
      side  <= side_live;
      level <= '0;
      count <= '0;
      best  <= '0;
    end
    if (cmd.start || cmd.level_end) begin
      init_idx <= '0;
      ir       <= '0;
      ic       <= '0;
      sr       <= '0;
      sc       <= '0;
    end
    if (cmd.level_end) begin
      best  <= (count > best) ? count : best;
      count <= '0;
      level <= level + LEVEL_W'(1);
    end
    if (cmd.init_rd) begin
      init_idx <= init_idx + ADDR_W'(1);
      if (at_edge(ic, side_x)) begin
        ic <= '0;
        ir <= ir + COORD_W'(1);
      end else begin
        ic <= ic + COORD_W'(1);
      end
    end
    if (cmd.scan_next) begin
      if (at_edge(sc, side_x)) begin
        sc <= '0;
        sr <= sr + COORD_W'(1);
      end else begin
        sc <= sc + COORD_W'(1);
      end
    end
    if (cmd.scan_hit) begin
      if (count != COUNT_W'(COUNT_LIMIT)) begin
        count <= count + COUNT_W'(1);
      end
      sp <= IDX_W'(1);
    end
    if (cmd.pop_rd) begin
      sp <= sp_m1;
    end
    if (cmd.nb_push) begin
      sp <= sp + IDX_W'(1);
    end
    if (cmd.pop_take) begin
      cur_r <= stk_rdata[RC_W-1:COORD_W];
      cur_c <= stk_rdata[COORD_W-1:0];
      nb    <= DIR_RIGHT;
    end
    if (cmd.nb_next) begin
      nb <= nb + 2'd1;
    end
    if (cmd.emit) begin
      max_regions <= best;
    end
  end

  // Height store, linear row-major address
  tcr_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (CELL_COUNT)
  ) u_height (
    .clk   (clk),
    .we    (cmd.load_wr && load_ok),
    .waddr (load_index[ADDR_W-1:0]),
    .wdata (height),
    .re    (cmd.init_rd),
    .raddr (init_idx),
    .rdata (h_rdata)
  );

  // Visited map, addressed by {row, col}; flooded cells start out marked
  assign vis_we    = pend_valid | cmd.scan_hit | cmd.nb_push;
  assign vis_wdata = pend_valid ? (h_rdata <= level) : 1'b1;
  assign vis_re    = cmd.scan_rd | cmd.nb_rd;
  assign vis_raddr = cmd.scan_rd ? {sr, sc} : {nb_r, nb_c};

  always_comb begin
    priority if (pend_valid) begin
      vis_waddr = pend_rc;
    end else if (cmd.scan_hit) begin
      vis_waddr = {sr, sc};
    end else begin
      vis_waddr = {nb_r, nb_c};
    end
  end

  tcr_ram #(
    .WIDTH (1),
    .DEPTH (VIS_DEPTH)
  ) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .re    (vis_re),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  // Walk stack of {row, col} entries
  assign stk_we    = cmd.scan_hit | cmd.nb_push;
  assign stk_waddr = cmd.scan_hit ? '0 : sp[ADDR_W-1:0];
  assign stk_wdata = cmd.scan_hit ? {sr, sc} : {nb_r, nb_c};

  tcr_ram #(
    .WIDTH (RC_W),
    .DEPTH (CELL_COUNT)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (cmd.pop_rd),
    .raddr (sp_m1[ADDR_W-1:0]),
    .rdata (stk_rdata)
  );

  // Status back to the sequencer
  always_comb begin
    sts.init_last  = at_edge(ir, side_x) && at_edge(ic, side_x);
    sts.scan_last  = at_edge(sr, side_x) && at_edge(sc, side_x);
    sts.vis_free   = !vis_rdata;
    sts.sp_zero    = (sp == '0);
    sts.nb_ok      = nb_ok;
    sts.nb_last    = (nb == DIR_UP);
    sts.level_last = (level == LEVEL_W'(LEVEL_TOP));
  end

endmodule

`default_nettype wire

/* sv/threshold_region_counter.sv */
// Top level of the threshold region counter.
//
// Usage: heights arrive on the input channel (in_valid/in_ready, height,
// last_cell) in row-major order, one request per cycle while loading.
// The request with last_cell set closes the grid of grid_side x grid_side
// cells (side written through cfg_wr_en/cfg_wr_data, 0 acts as 1, reset 64)
// and starts the count; in_ready is low until it finishes.
// For each water level 0..255 the block floods the grid, scans every cell
// and walks each dry region with a stack; the visited map and stack memories
// each have a single read port. The result sits in an output register
// (out_valid/out_ready); while it waits, the next grid can load, and a
// finished count waits for the register to free. Synchronous active-high
// rst empties the result register, returns to the load phase at cell 0 and
// sets grid_side to 64. Height contents are kept.
`default_nettype none
`include "threshold_region_counter_defines.svh"

module threshold_region_counter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [tcr_pkg::SIDE_W-1:0]     cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tcr_pkg::HEIGHT_W-1:0]   height,
  input  wire logic                           last_cell,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [tcr_pkg::COUNT_W-1:0]    max_regions
);

  import tcr_pkg::*;

  tcr_cmd_t cmd;
  tcr_sts_t sts;

  tcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_cell (last_cell),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tcr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .height      (height),
    .max_regions (max_regions),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Busy right after the closing cell is taken
  `TCR_ASSERT_NEXT(a_busy_after_last, clk, rst, in_valid && in_ready && last_cell, !in_ready)
  // A new result never overwrites one still waiting
  `TCR_ASSERT_IMPL(a_emit_free, clk, rst, cmd.emit, !out_valid || out_ready)
  // Never pop an empty stack
  `TCR_ASSERT_NEVER(a_pop_empty, clk, rst, cmd.pop_rd && sts.sp_zero)
  // Region count cannot exceed half the cells, rounded up
  `TCR_ASSERT_IMPL(a_count_bound, clk, rst, out_valid, int'(max_regions) <= (CELL_COUNT + 1) / 2)

endmodule

`default_nettype wire
